// ----- sv/cvr_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and colormap knot tables for colormap_value_to_rgb.
// No dependencies; imported by every module of the block.
package cvr_pkg;

  // Bits of the scaled value below the binary point
  localparam int FracBits = 32;
  localparam int QuoCntW  = 5;

  // Positions of the s_axis_tuser fields
  localparam int UserOpcode  = 0;
  localparam int UserInvalid = 1;
  localparam int UserGroup   = 2;
  localparam int UserRestart = 3;
  localparam int UserW       = 4;

  localparam logic [7:0] OutsideLevel = 8'd26;
  localparam logic [7:0] InvalidLevel = 8'd255;
  localparam logic [7:0] ZeroLevel    = 8'd0;

  // floor(y / 3) == (y * RecipThird) >> RecipShift for y < 8192
  localparam logic [11:0] RecipThird = 12'd2731;
  localparam int          RecipShift = 13;

  typedef enum logic {
    OP_SCAN,
    OP_COLOR
  } cvr_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_INTERP,
    ST_DONE
  } cvr_state_e;

  typedef enum logic [2:0] {
    IP_IDLE,
    IP_SEG,
    IP_MUL,
    IP_ADJ,
    IP_QUO,
    IP_FIN
  } cvr_ip_state_e;

  typedef enum logic [1:0] {
    CH_RED,
    CH_GREEN,
    CH_BLUE
  } cvr_chan_e;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } cvr_rgb_t;

  typedef struct packed {
    logic     mapped;
    cvr_rgb_t rgb;
  } cvr_result_t;

  // Knot positions in twentieths of the range
  function automatic logic [4:0] knot_pos(input logic [2:0] idx);
    logic [4:0] pos;
    case (idx)
      3'd0:    pos = 5'd0;
      3'd1:    pos = 5'd3;
      3'd2:    pos = 5'd7;
      3'd3:    pos = 5'd13;
      3'd4:    pos = 5'd17;
      3'd5:    pos = 5'd20;
      default: pos = 5'd20;
    endcase
    return pos;
  endfunction

  // Knot colours on a 0..255 scale
  function automatic logic [7:0] knot_col(input cvr_chan_e ch, input logic [2:0] idx);
    logic [7:0] col;
    col = 8'd0;
    case (ch)
      CH_RED: begin
        case (idx)
          3'd3, 3'd4, 3'd5: col = 8'd255;
          default:          col = 8'd0;
        endcase
      end
      CH_GREEN: begin
        case (idx)
          3'd1:       col = 8'd50;
          3'd2, 3'd3: col = 8'd255;
          3'd4:       col = 8'd30;
          default:    col = 8'd0;
        endcase
      end
      CH_BLUE: begin
        case (idx)
          3'd0:       col = 8'd100;
          3'd1, 3'd2: col = 8'd255;
          default:    col = 8'd0;
        endcase
      end
      default: col = 8'd0;
    endcase
    return col;
  endfunction

endpackage

// ----- sv/colormap_value_to_rgb.sv -----
`timescale 1ns / 1ps
// Top level: range tracking, item sequencing and output register of the colormap.
// Depends on cvr_pkg, cvr_divider and cvr_interp.
//
// Input stream: s_axis_tdata_i carries the signed Q16.16 sample, s_axis_tuser_i the
// opcode, invalid, group and restart flags. A transfer is taken when tvalid and tready
// are both high. Scan transfers widen (or, after a restart, replace) the held range and
// give no output. Colour transfers give exactly one output transfer with red, green,
// blue in m_axis_tdata_o and the mapped flag in m_axis_tuser_o. A colour item outside
// the group or with an invalid sample goes straight from idle to the done state. An
// item with an empty range or a sample outside it passes through the prep state to done.
// A sample on the top of the range skips the divider and goes straight to the
// interpolator. Any other colour item runs through the 32-step fractional divider (one
// quotient bit per cycle), then the interpolator steps through its multiply, adjust,
// quotient and finish states for each channel. One item is in work at a time.
// The result sits in an output register, so a stalled receiver only holds the block
// once the next result is ready to leave. Reset clears the range to zero and marks it
// for replacement by the next valid scan sample.
module colormap_value_to_rgb import cvr_pkg::*; #(
  parameter int SAMPLE_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // sample
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata_i,
  // opcode, sample_invalid, in_group, restart_range
  input  logic [UserW-1:0]                    s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // red, green, blue
  output logic [23:0]                         m_axis_tdata_o,
  // mapped
  output logic [0:0]                          m_axis_tuser_o
);

  cvr_state_e state_q, state_d;

  logic signed [SAMPLE_BITS-1:0] low_q;
  logic signed [SAMPLE_BITS-1:0] high_q;
  logic                          pend_q;
  logic signed [SAMPLE_BITS-1:0] samp_q;
  cvr_result_t                   res_q;
  cvr_result_t                   out_q;
  logic                          out_valid_q;

  logic signed [SAMPLE_BITS-1:0] in_sample;
  cvr_op_e                       in_op;
  logic                          in_inv;
  logic                          in_grp;
  logic                          in_rst;
  logic                          accept;
  logic                          pend_eff;

  logic [SAMPLE_BITS-1:0]        num;
  logic [SAMPLE_BITS-1:0]        den;
  logic                          outside;
  logic                          at_top;

  logic                          div_start;
  logic                          div_done;
  logic [FracBits-1:0]           div_quo;
  logic                          ip_start;
  logic [FracBits:0]             ip_frac;
  logic                          ip_done;
  cvr_rgb_t                      ip_rgb;
  logic                          out_free;

  assign in_sample = s_axis_tdata_i[SAMPLE_BITS-1:0];
  assign in_op     = cvr_op_e'(s_axis_tuser_i[UserOpcode]);
  assign in_inv    = s_axis_tuser_i[UserInvalid];
  assign in_grp    = s_axis_tuser_i[UserGroup];
  assign in_rst    = s_axis_tuser_i[UserRestart];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign pend_eff        = pend_q | in_rst;
  assign out_free        = !out_valid_q || m_axis_tready_i;

  always_comb begin
    num     = samp_q - low_q;
    den     = high_q - low_q;
    outside = (samp_q < low_q) || (high_q < samp_q) || (high_q == low_q);
    at_top  = (samp_q == high_q);
  end

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    ip_start  = 1'b0;
    ip_frac   = {1'b0, div_quo};
    case (state_q)
      ST_IDLE: begin
        if (accept && in_op == OP_COLOR) begin
          if (!in_grp || in_inv) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        if (outside) begin
          state_d = ST_DONE;
        end else if (at_top) begin
          // Sample on the top of the range scales to exactly one
          ip_start = 1'b1;
          ip_frac  = {1'b1, {FracBits{1'b0}}};
          state_d  = ST_INTERP;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          ip_start = 1'b1;
          state_d  = ST_INTERP;
        end
      end
      ST_INTERP: if (ip_done) state_d = ST_DONE;
      ST_DONE:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      low_q       <= '0;
      high_q      <= '0;
      pend_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        pend_q <= pend_eff;
        if (in_op == OP_SCAN && !in_inv) begin
          if (pend_eff) begin
            low_q  <= in_sample;
            high_q <= in_sample;
            pend_q <= 1'b0;
          end else begin
            if (in_sample < low_q) low_q <= in_sample;
            if (high_q < in_sample) high_q <= in_sample;
          end
        end
      end
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      samp_q <= in_sample;
      if (!in_grp) begin
        res_q <= '{mapped: 1'b1, rgb: '{OutsideLevel, OutsideLevel, OutsideLevel}};
      end else begin
        res_q <= '{mapped: 1'b1, rgb: '{InvalidLevel, InvalidLevel, InvalidLevel}};
      end
    end else if (state_q == ST_PREP && outside) begin
      res_q <= '{mapped: 1'b0, rgb: '{ZeroLevel, ZeroLevel, ZeroLevel}};
    end else if (state_q == ST_INTERP && ip_done) begin
      res_q <= '{mapped: 1'b1, rgb: ip_rgb};
    end
    if (state_q == ST_DONE && out_free) begin
      out_q <= res_q;
    end
  end

  cvr_divider #(
    .SampleBits(SAMPLE_BITS)
  ) u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (num),
    .den_i  (den),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  cvr_interp u_interp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(ip_start),
    .frac_i (ip_frac),
    .done_o (ip_done),
    .rgb_o  (ip_rgb)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_q.rgb.blue, out_q.rgb.green, out_q.rgb.red};
  assign m_axis_tuser_o  = out_q.mapped;

endmodule

// ----- sv/cvr_divider.sv -----
`timescale 1ns / 1ps
// Restoring fractional divider: floor(num * 2^FracBits / den), one quotient bit per cycle.
// Depends on cvr_pkg; requires num < den.
module cvr_divider import cvr_pkg::*; #(
  parameter int SampleBits = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [SampleBits-1:0] num_i,
  input  logic [SampleBits-1:0] den_i,
  output logic                  done_o,
  output logic [FracBits-1:0]   quo_o
);

  localparam logic [QuoCntW-1:0] LastStep = QuoCntW'(FracBits - 1);

  logic                  busy_q;
  logic                  done_q;
  logic [QuoCntW-1:0]    cnt_q;
  logic [SampleBits-1:0] rem_q;
  logic [SampleBits-1:0] den_q;
  logic [FracBits-1:0]   quo_q;

  logic [SampleBits:0]   rem_sh;
  logic [SampleBits:0]   trial;
  logic                  fits;

  always_comb begin
    rem_sh = {rem_q, 1'b0};
    trial  = rem_sh - {1'b0, den_q};
    fits   = ~trial[SampleBits];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LastStep) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Shift one quotient bit in per cycle; keep the remainder below den
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      den_q <= den_i;
      quo_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[FracBits-2:0], fits};
      if (fits) begin
        rem_q <= trial[SampleBits-1:0];
      end else begin
        rem_q <= rem_sh[SampleBits-1:0];
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ----- sv/cvr_interp.sv -----
`timescale 1ns / 1ps
// Segment lookup and linear interpolation of the three channels, one channel at a time.
// Depends on cvr_pkg for knot tables and types.
module cvr_interp import cvr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [FracBits:0] frac_i,
  output logic              done_o,
  output cvr_rgb_t          rgb_o
);

  cvr_ip_state_e state_q, state_d;
  cvr_chan_e     ch_q;
  logic          done_q;

  logic [FracBits:0]     s_q;
  logic [2:0]            seg_q;
  logic [FracBits+2:0]   u_q;
  logic signed [44:0]    p_q;
  logic [11:0]           yp_q;
  logic [8:0]            q_q;
  cvr_rgb_t              rgb_q;

  logic [FracBits+4:0]   v20;
  logic [4:0]            intg;
  logic [2:0]            seg;
  logic [4:0]            ui;
  logic [4:0]            wdt;
  logic [2:0]            w3;
  logic [7:0]            col_a;
  logic [7:0]            col_b;
  logic signed [8:0]     diff;
  logic signed [44:0]    prod;
  logic signed [44:0]    xsum;
  logic [11:0]           bias;
  logic [11:0]           yp;
  logic [11:0]           dvd;
  logic [23:0]           recip;
  logic [8:0]            qv;
  logic signed [10:0]    chv;
  logic [7:0]            chan;

  always_comb begin
    v20  = ({4'b0, s_q} << 4) + ({4'b0, s_q} << 2);
    intg = v20[FracBits+4:FracBits];
    if (intg >= knot_pos(3'd4)) begin
      seg = 3'd4;
    end else if (intg >= knot_pos(3'd3)) begin
      seg = 3'd3;
    end else if (intg >= knot_pos(3'd2)) begin
      seg = 3'd2;
    end else if (intg >= knot_pos(3'd1)) begin
      seg = 3'd1;
    end else begin
      seg = 3'd0;
    end
    ui = intg - knot_pos(seg);

    wdt   = knot_pos(seg_q + 3'd1) - knot_pos(seg_q);
    w3    = wdt[2:0];
    col_a = knot_col(ch_q, seg_q);
    col_b = knot_col(ch_q, seg_q + 3'd1);
    diff  = $signed({1'b0, col_b}) - $signed({1'b0, col_a});
    prod  = diff * $signed({1'b0, u_q});

    // Add half a segment, drop the fraction, bias by 255 * width so it stays positive
    xsum = p_q + $signed({11'b0, w3, 31'b0});
    bias = {1'b0, w3, 8'b0} - {9'b0, w3};
    yp   = xsum[43:32] + bias;

    case (w3)
      3'd6:    dvd = {1'b0, yp_q[11:1]};
      default: dvd = yp_q;
    endcase
    recip = {12'b0, dvd} * {12'b0, RecipThird};
    case (w3)
      3'd4:    qv = yp_q[10:2];
      default: qv = recip[RecipShift +: 9];
    endcase

    chv = $signed({3'b0, col_a}) + $signed({2'b0, q_q}) - 11'sd255;
    if (chv < 0) begin
      chan = 8'd0;
    end else if (chv > 11'sd255) begin
      chan = 8'd255;
    end else begin
      chan = chv[7:0];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      IP_IDLE: if (start_i) state_d = IP_SEG;
      IP_SEG:  state_d = IP_MUL;
      IP_MUL:  state_d = IP_ADJ;
      IP_ADJ:  state_d = IP_QUO;
      IP_QUO:  state_d = IP_FIN;
      IP_FIN: begin
        if (ch_q == CH_BLUE) begin
          state_d = IP_IDLE;
        end else begin
          state_d = IP_MUL;
        end
      end
      default: state_d = IP_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IP_IDLE;
      ch_q    <= CH_RED;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == IP_FIN) && (ch_q == CH_BLUE);
      case (state_q)
        IP_SEG: ch_q <= CH_RED;
        IP_FIN: begin
          case (ch_q)
            CH_RED:   ch_q <= CH_GREEN;
            CH_GREEN: ch_q <= CH_BLUE;
            default:  ch_q <= CH_RED;
          endcase
        end
        default: ch_q <= ch_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      IP_IDLE: if (start_i) s_q <= frac_i;
      IP_SEG: begin
        seg_q <= seg;
        u_q   <= {ui[2:0], v20[FracBits-1:0]};
      end
      IP_MUL: p_q  <= prod;
      IP_ADJ: yp_q <= yp;
      IP_QUO: q_q  <= qv;
      IP_FIN: begin
        case (ch_q)
          CH_RED:   rgb_q.red   <= chan;
          CH_GREEN: rgb_q.green <= chan;
          default:  rgb_q.blue  <= chan;
        endcase
      end
      default: s_q <= s_q;
    endcase
  end

  assign done_o = done_q;
  assign rgb_o  = rgb_q;

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for colormap_value_to_rgb: directed and random scan and colour
// transfers, with an in-bench colour predictor. Depends on cvr_pkg and the block's RTL.
module testbench;
  import cvr_pkg::*;

  localparam int  CycleLimit = 1000000;
  localparam int  ItemTarget = 800;
  localparam int  TailCycles = 60;
  localparam longint SMin = -64'sd2147483648;
  localparam longint SMax = 64'sd2147483647;

  localparam int KnotAt [6] = '{0, 3, 7, 13, 17, 20};
  localparam int KnotRed [6] = '{0, 0, 0, 255, 255, 255};
  localparam int KnotGreen [6] = '{0, 50, 255, 255, 30, 0};
  localparam int KnotBlue [6] = '{100, 255, 255, 0, 0, 0};

  typedef struct {
    cvr_op_e     op;
    logic [31:0] sample;
    logic        invalid;
    logic        group;
    logic        restart;
    logic        drain;  // hold this transfer until every colour has come back
  } pix_item_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid_i = 1'b0;
  logic             s_axis_tready_o;
  logic [31:0]      s_axis_tdata_i = '0;
  logic [UserW-1:0] s_axis_tuser_i = '0;
  logic             m_axis_tvalid_o;
  logic             m_axis_tready_i = 1'b0;
  logic [23:0]      m_axis_tdata_o;
  logic [0:0]       m_axis_tuser_o;

  pix_item_t   pending_items[$];
  pix_item_t   on_bus;
  cvr_result_t rgb_due[$];
  longint      span_lo = 0;
  longint      span_hi = 0;
  bit          refill_pending = 1'b1;
  int          fail_cnt = 0;
  int          counted = 0;
  int          cycle_cnt = 0;
  int          send_gap = 0;
  int          recv_gap = 0;
  bit          send_busy = 1'b1;
  bit          recv_busy = 1'b1;
  bit          in_taken = 1'b0;

  colormap_value_to_rgb #(.SAMPLE_BITS(32)) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #6 clk_i = ~clk_i;

  // Mostly short gaps, a few long ones; none at all while quiet
  function automatic int pick_gap(input bit busy);
    int r;
    r = $urandom_range(0, 99);
    if (!busy || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic cvr_result_t colour_of(input longint v, input longint lo,
                                            input longint hi);
    cvr_result_t res;
    logic [63:0] num, den64, frac, v20;
    longint      u, seg_len, tot;
    int          seg, a, b, ch;
    res = '0;
    if (hi != lo && v >= lo && v <= hi) begin
      num   = 64'(v - lo);
      den64 = 64'(hi - lo);
      frac  = (num >= den64) ? (64'd1 << 32) : ((num << 32) / den64);
      v20   = frac * 64'd20;
      seg = 0;
      for (int k = 1; k < 5; k++)
        if ((64'(KnotAt[k]) << 32) <= v20) seg = k;
      u       = longint'(v20) - (longint'(KnotAt[seg]) << 32);
      seg_len = longint'(KnotAt[seg + 1] - KnotAt[seg]) << 32;
      for (int c = 0; c < 3; c++) begin
        case (c)
          0:       begin a = KnotRed[seg];   b = KnotRed[seg + 1];   end
          1:       begin a = KnotGreen[seg]; b = KnotGreen[seg + 1]; end
          default: begin a = KnotBlue[seg];  b = KnotBlue[seg + 1];  end
        endcase
        tot = longint'(a) * seg_len + longint'(b - a) * u;
        ch  = int'((tot + seg_len / 2) / seg_len);
        if (ch > 255) ch = 255;
        case (c)
          0:       res.rgb.red   = 8'(ch);
          1:       res.rgb.green = 8'(ch);
          default: res.rgb.blue  = 8'(ch);
        endcase
      end
      res.mapped = 1'b1;
    end
    return res;
  endfunction

  // Advance the held range, or queue the colour this transfer must produce
  task automatic track_range_and_colour(input pix_item_t it);
    longint      v;
    cvr_result_t res;
    v = longint'($signed(it.sample));
    if (it.restart) refill_pending = 1'b1;
    if (it.op == OP_SCAN) begin
      if (!it.invalid) begin
        if (refill_pending) begin
          span_lo = v;
          span_hi = v;
          refill_pending = 1'b0;
        end else begin
          if (v < span_lo) span_lo = v;
          if (v > span_hi) span_hi = v;
        end
      end
    end else begin
      if (!it.group) begin
        res.mapped = 1'b1;
        res.rgb    = '{blue: OutsideLevel, green: OutsideLevel, red: OutsideLevel};
      end else if (it.invalid) begin
        res.mapped = 1'b1;
        res.rgb    = '{blue: InvalidLevel, green: InvalidLevel, red: InvalidLevel};
      end else begin
        res = colour_of(v, span_lo, span_hi);
      end
      rgb_due = {rgb_due, res};
    end
  endtask

  task automatic queue_item(input cvr_op_e op, input longint v, input bit invalid,
                            input bit group, input bit restart, input bit drain);
    pix_item_t it;
    it.op      = op;
    it.sample  = v[31:0];
    it.invalid = invalid;
    it.group   = group;
    it.restart = restart;
    it.drain   = drain;
    pending_items = {pending_items, it};
    if (!(op == OP_SCAN && invalid)) counted++;
  endtask

  function automatic longint rand_sample();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0:       return SMin;
      1:       return SMax;
      2:       return longint'($urandom_range(0, 2)) - 1;
      3, 4:    return longint'($urandom_range(0, 262144)) - 131072;
      default: return longint'($signed($urandom()));
    endcase
  endfunction

  function automatic longint inside_span(input longint lo, input longint hi);
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    if ($urandom_range(0, 3) == 0)
      return lo + ((hi - lo) * KnotAt[$urandom_range(0, 5)]) / 20;
    return lo + longint'(w % 64'(hi - lo + 1));
  endfunction

  function automatic longint outside_span(input longint lo, input longint hi);
    longint v;
    if ($urandom_range(0, 1) == 0) begin
      v = lo - 1 - longint'($urandom_range(0, 100000));
      if (v < SMin) v = SMin;
    end else begin
      v = hi + 1 + longint'($urandom_range(0, 100000));
      if (v > SMax) v = SMax;
    end
    return v;
  endfunction

  // Transfer acceptance, prediction and result checking
  always @(posedge clk_i) begin : watch_streams
    cvr_result_t want;
    cvr_rgb_t    got;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        in_taken = 1'b1;
        track_range_and_colour(on_bus);
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = cvr_rgb_t'(m_axis_tdata_o);
        if (rgb_due.size() == 0) begin
          $error("unexpected result: red %0d green %0d blue %0d mapped %0d",
                 got.red, got.green, got.blue, m_axis_tuser_o[0]);
          fail_cnt++;
        end else begin
          want = rgb_due.pop_front();
          if (got.red !== want.rgb.red) begin
            $error("red: expected %0d, got %0d", want.rgb.red, got.red);
            fail_cnt++;
          end
          if (got.green !== want.rgb.green) begin
            $error("green: expected %0d, got %0d", want.rgb.green, got.green);
            fail_cnt++;
          end
          if (got.blue !== want.rgb.blue) begin
            $error("blue: expected %0d, got %0d", want.rgb.blue, got.blue);
            fail_cnt++;
          end
          if (m_axis_tuser_o[0] !== want.mapped) begin
            $error("mapped: expected %0d, got %0d", want.mapped, m_axis_tuser_o[0]);
            fail_cnt++;
          end
        end
      end
    end
  end

  // Input driver: load a new transfer once the current one has gone
  always @(negedge clk_i) begin : drive_input
    pix_item_t        it;
    logic [UserW-1:0] flags;
    bit               next_valid;
    if (rst_ni && (!s_axis_tvalid_i || in_taken)) begin
      in_taken   = 1'b0;
      next_valid = 1'b0;
      if (send_gap != 0) begin
        send_gap--;
      end else if (pending_items.size() != 0 &&
                   !(pending_items[0].drain && rgb_due.size() != 0)) begin
        it = pending_items.pop_front();
        flags = '0;
        flags[UserOpcode]  = it.op;
        flags[UserInvalid] = it.invalid;
        flags[UserGroup]   = it.group;
        flags[UserRestart] = it.restart;
        on_bus <= it;
        s_axis_tdata_i <= it.sample;
        s_axis_tuser_i <= flags;
        next_valid = 1'b1;
        if ($urandom_range(0, 39) == 0) send_busy = !send_busy;
        send_gap = pick_gap(send_busy);
      end
      s_axis_tvalid_i <= next_valid;
    end
  end

  // Receiver back-pressure
  always @(negedge clk_i) begin : drive_ready
    if (rst_ni) begin
      if ($urandom_range(0, 199) == 0) recv_busy = !recv_busy;
      if (recv_gap == 0 && $urandom_range(0, 3) == 0) recv_gap = pick_gap(recv_busy);
      if (recv_gap != 0) begin
        recv_gap--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("colormap_value_to_rgb regression: fail");
      $finish;
    end
  end

  initial begin : stimulus
    longint lo, hi, span;
    int     r;
    // Directed: empty range from reset, group and invalid precedence
    queue_item(OP_COLOR, 0, 0, 1, 0, 0);
    queue_item(OP_COLOR, 0, 0, 0, 0, 0);
    queue_item(OP_COLOR, 7, 1, 1, 0, 0);
    queue_item(OP_COLOR, 7, 1, 0, 0, 0);
    // invalid scan leaves the refill pending; scans ignore the group bit
    queue_item(OP_SCAN, 5, 1, 1, 0, 0);
    queue_item(OP_SCAN, SMin, 0, 0, 0, 0);
    queue_item(OP_COLOR, SMin, 0, 1, 0, 0);
    queue_item(OP_SCAN, SMax, 0, 1, 0, 0);
    queue_item(OP_COLOR, SMin, 0, 1, 0, 0);
    queue_item(OP_COLOR, SMax, 0, 1, 0, 0);
    queue_item(OP_COLOR, 0, 0, 1, 0, 0);
    queue_item(OP_COLOR, -1, 0, 1, 0, 0);
    // range 0.0 .. 20.0: exact knots and both sides out of range
    queue_item(OP_SCAN, 0, 0, 0, 1, 1);
    queue_item(OP_SCAN, 20 * 65536, 0, 1, 0, 0);
    for (int k = 1; k < 5; k++) queue_item(OP_COLOR, KnotAt[k] * 65536, 0, 1, 0, 0);
    queue_item(OP_COLOR, 20 * 65536 + 1, 0, 1, 0, 0);
    queue_item(OP_COLOR, -1, 0, 1, 0, 0);
    // restart on a colour maps with the old range
    queue_item(OP_COLOR, 10 * 65536, 0, 1, 1, 0);
    queue_item(OP_SCAN, 123, 1, 1, 0, 0);
    queue_item(OP_SCAN, 2, 0, 1, 0, 0);
    queue_item(OP_SCAN, 1, 0, 0, 0, 0);
    queue_item(OP_COLOR, 1, 0, 1, 0, 0);
    queue_item(OP_COLOR, 2, 0, 1, 0, 1);

    // Random: restart, fill a range, then mostly colour it
    while (counted < ItemTarget) begin
      r = $urandom_range(0, 9);
      case (r)
        0:       span = 0;
        1, 2:    span = $urandom_range(1, 40);
        3, 4:    span = 20 * longint'($urandom_range(1, 3000));
        5, 6:    span = longint'($urandom_range(1, 1 << 24));
        7:       span = longint'($urandom());
        default: span = $urandom_range(0, 1) ? (SMax - SMin) : longint'($urandom()) + 1;
      endcase
      lo = (span >= SMax - SMin) ? SMin : rand_sample();
      if (lo + span > SMax) lo = SMax - span;
      hi = lo + span;
      if ($urandom_range(0, 4) == 0)
        queue_item(OP_SCAN, rand_sample(), 1, $urandom_range(0, 1), 1, 0);
      queue_item(OP_SCAN, lo, 0, $urandom_range(0, 1), 1, $urandom_range(0, 5) == 0);
      queue_item(OP_SCAN, hi, 0, $urandom_range(0, 1), 0, 0);
      repeat ($urandom_range(0, 4))
        queue_item(OP_SCAN, inside_span(lo, hi), $urandom_range(0, 7) == 0,
                   $urandom_range(0, 1), 0, 0);
      repeat ($urandom_range(4, 14)) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          queue_item(OP_COLOR, inside_span(lo, hi), 0, 1, 0, 0);
        end else if (r < 78) begin
          queue_item(OP_COLOR, outside_span(lo, hi), 0, 1, 0, 0);
        end else if (r < 84) begin
          queue_item(OP_COLOR, rand_sample(), $urandom_range(0, 1), 0, 0, 0);
        end else if (r < 90) begin
          queue_item(OP_COLOR, rand_sample(), 1, 1, 0, 0);
        end else if (r < 95) begin
          lo = (lo < SMin + 1000) ? SMin : lo - longint'($urandom_range(0, 1000));
          queue_item(OP_SCAN, lo, 0, $urandom_range(0, 1), 0, 0);
        end else begin
          queue_item(OP_COLOR, inside_span(lo, hi), 0, 1, 1, 0);
        end
      end
    end

    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_items.size() != 0 || s_axis_tvalid_i) @(posedge clk_i);
    while (rgb_due.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("colormap_value_to_rgb regression: pass");
    end else begin
      $display("colormap_value_to_rgb regression: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/cvr_pkg.sv
sv/cvr_divider.sv
sv/cvr_interp.sv
sv/colormap_value_to_rgb.sv
verif/testbench.sv
